FILE: hw/rtl/imd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types for the integer matrix determinant block.
// ----------------------------------------------------------------------------
package imd_pkg;

   localparam int WORD_WIDTH = 64;
   localparam int SIZE_WIDTH = 6;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_LOAD,
      ST_COL_START,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_SWP_RD_A,
      ST_SWP_RD_B,
      ST_SWP_WR_A,
      ST_SWP_WR_B,
      ST_RED_START,
      ST_RED_RD_DEN,
      ST_RED_RD_NUM,
      ST_DIV,
      ST_UPD_RD_P,
      ST_UPD_RD_R,
      ST_UPD_MUL,
      ST_UPD_WR,
      ST_RED_CHK,
      ST_DET_RD,
      ST_DET_MUL,
      ST_DONE
   } state_type;

   // Magnitude of a 64-bit two's complement pattern.
   function automatic word_type mag(input word_type v);
      mag = v[WORD_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

endpackage : imd_pkg
`default_nettype wire

FILE: hw/rtl/integer_matrix_determinant.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_matrix_determinant
// Exact determinant of a square integer matrix by Euclidean elimination.
// ----------------------------------------------------------------------------
// Elements load at one word per cycle while no size write is offered. After the
// last one the input is not ready until the determinant word is taken. A quotient
// step runs the shared divider, then updates each entry of the row with a 3-pass
// 32 by 32 multiplier, which also forms the diagonal product.
// Synchronous active-high reset clears the sequencer, the load count and the
// size register (to 1); the matrix memory is not cleared.
module integer_matrix_determinant
   import imd_pkg::*;
#(
   parameter int MAX_SIZE      = 32,
   parameter int ELEMENT_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [SIZE_WIDTH-1:0]           csr_matrix_size,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic signed [ELEMENT_WIDTH-1:0] req_element_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [63:0]                   rsp_determinant
);

   localparam int IDX_W   = $clog2(MAX_SIZE);
   localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = ADDR_W + 1;
   localparam logic [1:0] MUL_LAST = 2'd2;

   // The matrix memory: one port, registered read.
   word_type mem [DEPTH];
   word_type rd_data_ff;
   logic [ADDR_W-1:0] addr;
   logic              wr_en;
   word_type          wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   state_type state_ff, state_in;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic [IDX_W:0]        n;            // effective size, 1..MAX_SIZE
   logic [CNT_W-1:0]      load_ff, load_in;
   logic [IDX_W:0]        col_ff, col_in;  // current pivot column
   logic [IDX_W:0]        row_ff, row_in;  // current lower row
   logic [IDX_W:0]        k_ff, k_in;      // sweep column
   logic                  sign_ff, sign_in;
   logic                  swap_red_ff, swap_red_in; // swap came from reduction
   word_type              tmp_ff, tmp_in;    // swap temp / pivot row value
   word_type              q_ff, q_in;
   word_type              den_ff, den_in;
   word_type              prod_ff, prod_in;
   word_type              det_ff, det_in;
   word_type              red_ff, red_in;    // reduced entry under the pivot
   logic [1:0]            mph_ff, mph_in;    // multiplier pass
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  div_start;
   logic                  div_busy;
   word_type              div_q;
   word_type              mul_x, mul_y, mul_p, mul_sum;
   logic [31:0]           mul_a, mul_b;

   imd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (den_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // One shared 32 by 32 multiplier builds the low 64 bits of a product in
   // three passes: low by low, then low by high, then high by low. The two
   // cross terms only matter in their low 32 bits.
   always_comb begin
      if (state_ff == ST_DET_MUL) begin
         mul_x = det_ff;
         mul_y = rd_data_ff;
      end else begin
         mul_x = q_ff;
         mul_y = tmp_ff;
      end
      case (mph_ff)
         2'd0: begin
            mul_a = mul_x[31:0];
            mul_b = mul_y[31:0];
         end
         2'd1: begin
            mul_a = mul_x[31:0];
            mul_b = mul_y[63:32];
         end
         default: begin
            mul_a = mul_x[63:32];
            mul_b = mul_y[31:0];
         end
      endcase
      mul_p = mul_a * mul_b;
      if (mph_ff == 2'd0) begin
         mul_sum = mul_p;
      end else begin
         mul_sum = prod_ff + {mul_p[31:0], 32'd0};
      end
   end

   // Effective size: zero counts as one, large values saturate.
   always_comb begin
      if (size_ff == '0) begin
         n = (IDX_W+1)'(1);
      end else if (32'(size_ff) > MAX_SIZE) begin
         n = (IDX_W+1)'(MAX_SIZE);
      end else begin
         n = (IDX_W+1)'(size_ff);
      end
   end

   // Flat address of (r, c) in an n by n row-major layout.
   function automatic logic [ADDR_W-1:0] at(input logic [IDX_W:0] r,
                                            input logic [IDX_W:0] c,
                                            input logic [IDX_W:0] nn);
      logic [2*IDX_W+2:0] a;
      a  = r * nn + c;
      at = a[ADDR_W-1:0];
   endfunction

   logic [CNT_W-1:0] nsq;
   logic [2*IDX_W+1:0] nsq_full;
   assign nsq_full = n * n;
   assign nsq      = nsq_full[CNT_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_ready && (load_ff + 1'b1 >= nsq)) begin
               state_in = ST_COL_START;
            end
         end
         ST_COL_START: state_in = (col_ff == n) ? ST_DET_RD : ST_PIV_RD;
         ST_PIV_RD:    state_in = ST_PIV_CHK;
         ST_PIV_CHK: begin
            if (rd_data_ff != '0) begin
               state_in = (row_ff == col_ff) ? ST_RED_START : ST_SWP_RD_A;
            end else if (row_ff + 1'b1 == n) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PIV_RD;
            end
         end
         ST_SWP_RD_A:  state_in = ST_SWP_RD_B;
         ST_SWP_RD_B:  state_in = ST_SWP_WR_A;
         ST_SWP_WR_A:  state_in = ST_SWP_WR_B;
         ST_SWP_WR_B: begin
            if (k_ff + 1'b1 != n) begin
               state_in = ST_SWP_RD_A;
            end else if (swap_red_ff) begin
               state_in = ST_RED_RD_DEN;
            end else begin
               state_in = ST_RED_START;
            end
         end
         ST_RED_START: state_in = (row_ff + 1'b1 >= n) ? ST_COL_START : ST_RED_RD_DEN;
         ST_RED_RD_DEN: state_in = ST_RED_RD_NUM;
         ST_RED_RD_NUM: state_in = ST_DIV;
         ST_DIV:        state_in = (!div_busy && !div_start) ? ST_UPD_RD_P : ST_DIV;
         ST_UPD_RD_P:   state_in = ST_UPD_RD_R;
         ST_UPD_RD_R:   state_in = ST_UPD_MUL;
         ST_UPD_MUL:    state_in = (mph_ff == MUL_LAST) ? ST_UPD_WR : ST_UPD_MUL;
         ST_UPD_WR:     state_in = (k_ff + 1'b1 == n) ? ST_RED_CHK : ST_UPD_RD_P;
         ST_RED_CHK: begin
            if (red_ff == '0) begin
               state_in = ST_RED_START;
            end else begin
               state_in = ST_SWP_RD_A;
            end
         end
         ST_DET_RD:  state_in = ST_DET_MUL;
         ST_DET_MUL: begin
            if (mph_ff == MUL_LAST) begin
               state_in = (k_ff + 1'b1 == n) ? ST_DONE : ST_DET_RD;
            end
         end
         ST_DONE:    state_in = (rsp_valid_ff && rsp_ready) ? ST_LOAD : ST_DONE;
         default:    state_in = ST_LOAD;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      load_in      = load_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      sign_in      = sign_ff;
      swap_red_in  = swap_red_ff;
      tmp_in       = tmp_ff;
      q_in         = q_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      det_in       = det_ff;
      red_in       = red_ff;
      mph_in       = '0;
      rsp_valid_in = rsp_valid_ff;
      addr         = '0;
      wr_en        = 1'b0;
      wr_data      = '0;
      div_start    = 1'b0;
      req_ready    = 1'b0;
      csr_ready    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = !csr_valid;
            csr_ready = 1'b1;
            if (csr_valid) begin
               load_in = '0;
            end else if (req_valid) begin
               addr    = (load_ff >= nsq) ? '0 : load_ff[ADDR_W-1:0];
               wr_en   = 1'b1;
               wr_data = WORD_WIDTH'(req_element_value);
               load_in = load_ff + 1'b1;
               if (load_ff + 1'b1 >= nsq || load_ff >= nsq) begin
                  load_in = '0;
                  col_in  = '0;
                  sign_in = 1'b0;
               end
               if (load_ff >= nsq) begin
                  load_in = CNT_W'(1);
                  if (nsq != CNT_W'(1)) begin
                     col_in = col_ff;
                  end
               end
            end
            row_in = '0;
         end
         ST_COL_START: begin
            row_in = col_ff;
         end
         ST_PIV_RD: begin
            addr = at(row_ff, col_ff, n);
         end
         ST_PIV_CHK: begin
            if (rd_data_ff != '0) begin
               k_in        = '0;
               swap_red_in = 1'b0;
               if (row_ff == col_ff) begin
                  row_in = col_ff;
               end
            end else if (row_ff + 1'b1 == n) begin
               det_in       = '0;
               rsp_valid_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_SWP_RD_A: begin
            addr = at(row_ff, k_ff, n);
         end
         ST_SWP_RD_B: begin
            addr   = at(col_ff, k_ff, n);
            tmp_in = rd_data_ff;
         end
         ST_SWP_WR_A: begin
            addr    = at(row_ff, k_ff, n);
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
         end
         ST_SWP_WR_B: begin
            addr    = at(col_ff, k_ff, n);
            wr_en   = 1'b1;
            wr_data = tmp_ff;
            k_in    = k_ff + 1'b1;
            if (k_ff + 1'b1 == n) begin
               sign_in = !sign_ff;
               if (!swap_red_ff) begin
                  row_in = col_ff;
               end
            end
         end
         ST_RED_START: begin
            row_in = row_ff + 1'b1;
         end
         ST_RED_RD_DEN: begin
            addr = at(col_ff, col_ff, n);
         end
         ST_RED_RD_NUM: begin
            addr      = at(row_ff, col_ff, n);
            den_in    = rd_data_ff;
         end
         ST_DIV: begin
            // Start on entry, then wait for the divider.
            div_start = (k_ff != col_ff) || !swap_red_ff;
            swap_red_in = 1'b1;
            k_in        = col_ff;
            if (!div_busy && !div_start) begin
               q_in = div_q;
            end
         end
         ST_UPD_RD_P: begin
            addr = at(col_ff, k_ff, n);
         end
         ST_UPD_RD_R: begin
            addr   = at(row_ff, k_ff, n);
            tmp_in = rd_data_ff;
         end
         ST_UPD_MUL: begin
            // The address is held so the row entry stays in the read register.
            addr    = at(row_ff, k_ff, n);
            prod_in = mul_sum;
            mph_in  = mph_ff + 2'd1;
            if (mph_ff == MUL_LAST) begin
               mph_in = '0;
               tmp_in = rd_data_ff;
            end
         end
         ST_UPD_WR: begin
            addr    = at(row_ff, k_ff, n);
            wr_en   = 1'b1;
            wr_data = tmp_ff - prod_ff;
            k_in    = k_ff + 1'b1;
            if (k_ff == col_ff) begin
               red_in = tmp_ff - prod_ff;
            end
         end
         ST_RED_CHK: begin
            // red_ff holds the reduced entry under the pivot.
            k_in = '0;
            swap_red_in = 1'b1;
         end
         ST_DET_RD: begin
            addr = at(k_ff, k_ff, n);
         end
         ST_DET_MUL: begin
            addr    = at(k_ff, k_ff, n);
            prod_in = mul_sum;
            mph_in  = mph_ff + 2'd1;
            if (mph_ff == MUL_LAST) begin
               mph_in = '0;
               det_in = mul_sum;
               k_in   = k_ff + 1'b1;
               if (k_ff + 1'b1 == n) begin
                  if (sign_ff) begin
                     det_in = ~mul_sum + 1'b1;
                  end
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (state_ff == ST_COL_START && col_ff == n) begin
         k_in   = '0;
         det_in = WORD_WIDTH'(1);
      end
      if (state_ff == ST_RED_START && row_ff + 1'b1 >= n) begin
         col_in = col_ff + 1'b1;
      end
      if (state_ff == ST_RED_START && row_ff + 1'b1 < n) begin
         swap_red_in = 1'b0;
         k_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         size_ff      <= SIZE_WIDTH'(1);
         load_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         swap_red_ff  <= 1'b0;
         mph_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         swap_red_ff  <= swap_red_in;
         mph_ff       <= mph_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_matrix_size;
         end
      end
      col_ff  <= col_in;
      row_ff  <= row_in;
      k_ff    <= k_in;
      tmp_ff  <= tmp_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      det_ff  <= det_in;
      red_ff  <= red_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = det_ff;

`ifndef SYNTHESIS
   a_no_req_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_ready)
      else $error("input accepted during elimination");
   a_rsp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_DONE))
      else $error("result shown outside the done state");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(det_ff)))
      else $error("result dropped before it was taken");
`endif

endmodule : integer_matrix_determinant
`default_nettype wire

FILE: hw/rtl/imd_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imd_divider
// Radix-2 restoring divider giving the truncated signed 64-bit quotient.
// ----------------------------------------------------------------------------
module imd_divider
   import imd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type dividend,
   input  wire word_type divisor,
   output logic          busy,
   output word_type      quotient
);

   word_type   rem_ff, rem_in;
   word_type   quo_ff, quo_in;
   word_type   den_ff, den_in;
   logic       neg_ff, neg_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   logic [WORD_WIDTH:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         rem_in  = '0;
         quo_in  = mag(dividend);
         den_in  = mag(divisor);
         neg_in  = dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
         cnt_in  = 7'(WORD_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // One quotient bit per cycle.
         trial = {rem_ff, quo_ff[WORD_WIDTH-1]} - {1'b0, den_ff};
         if (!trial[WORD_WIDTH]) begin
            rem_in = trial[WORD_WIDTH-1:0];
            quo_in = {quo_ff[WORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_WIDTH-2:0], quo_ff[WORD_WIDTH-1]};
            quo_in = {quo_ff[WORD_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule : imd_divider
`default_nettype wire
